// ===== hdl/qrs_pkg.sv =====
package qrs_pkg;

    localparam int COEF_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int OUT_BITS  = 36;

    // widths derived from the coefficient and fraction sizes
    localparam int PROD_BITS = 2 * COEF_BITS;
    localparam int DS_BITS   = 2 * COEF_BITS + 3;
    localparam int DM_BITS   = 2 * COEF_BITS + 1;
    localparam int SQ_BITS   = COEF_BITS + 1 + FRAC_BITS;
    localparam int REM_BITS  = SQ_BITS + 2;
    localparam int NUM_BITS  = SQ_BITS + 2;
    localparam int MAG_BITS  = SQ_BITS + 1;
    localparam int DEN_BITS  = COEF_BITS + 1;
    localparam int DVM_BITS  = COEF_BITS + 1;
    localparam int DREM_BITS = DVM_BITS + 1;
    localparam int WW_BITS   = ((MAG_BITS + 1 > OUT_BITS) ? MAG_BITS + 1 : OUT_BITS) + 1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NEG_DISC = 2'd1,
        ST_A_ZERO   = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] coef_a;
        logic signed [COEF_BITS-1:0] coef_b;
        logic signed [COEF_BITS-1:0] coef_c;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] root_plus;
        logic signed [OUT_BITS-1:0] root_minus;
        logic [1:0]                 status;
    } out_word_t;

    typedef struct packed {
        status_t                     status;
        logic [DM_BITS-1:0]          disc;
        logic signed [NUM_BITS-1:0]  nb;
        logic signed [DEN_BITS-1:0]  den;
    } job_t;

    typedef struct packed {
        status_t                     status;
        logic signed [NUM_BITS-1:0]  num_plus;
        logic signed [NUM_BITS-1:0]  num_minus;
        logic signed [DEN_BITS-1:0]  den;
    } sq_res_t;

endpackage

// ===== hdl/qrs_front.sv =====
module qrs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              coef_valid,
    output logic              coef_stall,
    input  qrs_pkg::in_word_t coefs,
    input  logic              q_full,
    output logic              push,
    output qrs_pkg::job_t     push_job
);
    import qrs_pkg::*;

    logic                        fr_valid_reg;
    logic signed [COEF_BITS-1:0] a_reg;
    logic signed [COEF_BITS-1:0] b_reg;
    logic signed [PROD_BITS-1:0] bb_reg;
    logic signed [PROD_BITS-1:0] ac_reg;
    logic signed [PROD_BITS-1:0] bb_next;
    logic signed [PROD_BITS-1:0] ac_next;
    logic signed [DS_BITS-1:0]   disc_s;
    logic                        load;

    assign coef_stall = fr_valid_reg && q_full;
    assign load       = !coef_stall;
    assign push       = fr_valid_reg && !q_full;

    assign bb_next = PROD_BITS'(coefs.coef_b * coefs.coef_b);
    assign ac_next = PROD_BITS'(coefs.coef_a * coefs.coef_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            fr_valid_reg <= coef_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg  <= coefs.coef_a;
            b_reg  <= coefs.coef_b;
            bb_reg <= bb_next;
            ac_reg <= ac_next;
        end
    end

    // classify and build the job word
    always_comb
    begin
        disc_s = DS_BITS'(bb_reg) - (DS_BITS'(ac_reg) <<< 2);
        if (a_reg == '0)
        begin
            push_job.status = ST_A_ZERO;
        end
        else if (disc_s < 0)
        begin
            push_job.status = ST_NEG_DISC;
        end
        else
        begin
            push_job.status = ST_OK;
        end
        push_job.disc = (push_job.status == ST_OK) ? disc_s[DM_BITS-1:0] : '0;
        push_job.nb   = -(NUM_BITS'(b_reg) <<< FRAC_BITS);
        push_job.den  = DEN_BITS'(a_reg) <<< 1;
    end

endmodule

// ===== hdl/qrs_queue.sv =====
module qrs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  qrs_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output qrs_pkg::job_t head
);
    import qrs_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    job_t       e0_reg;
    job_t       e1_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = e0_reg;

    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // two-slot shift queue, slot 0 is the head
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e0_reg <= (push && cnt_reg == 2'd1) ? push_job : e1_reg;
            if (push && cnt_reg == 2'd2)
            begin
                e1_reg <= push_job;
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                e0_reg <= push_job;
            end
            else
            begin
                e1_reg <= push_job;
            end
        end
    end

endmodule

// ===== hdl/qrs_sqrt.sv =====
module qrs_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  qrs_pkg::job_t    in_job,
    output logic             out_valid,
    output qrs_pkg::sq_res_t out_res
);
    import qrs_pkg::*;

    typedef struct packed {
        status_t                    status;
        logic [DM_BITS-1:0]         disc;
        logic signed [NUM_BITS-1:0] nb;
        logic signed [DEN_BITS-1:0] den;
        logic [REM_BITS-1:0]        rem;
        logic [SQ_BITS-1:0]         root;
    } sq_stage_t;

    logic      vld_reg [SQ_BITS+1];
    sq_stage_t st_reg  [SQ_BITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0].status <= in_job.status;
            st_reg[0].disc   <= in_job.disc;
            st_reg[0].nb     <= in_job.nb;
            st_reg[0].den    <= in_job.den;
            st_reg[0].rem    <= '0;
            st_reg[0].root   <= '0;
        end
    end

    // one root bit per stage, radicand pairs from the top down
    for (genvar k = 0; k < SQ_BITS; k++)
    begin : g_stage
        localparam int P = SQ_BITS - 1 - k;
        logic [2*SQ_BITS-1:0] rad;
        logic [REM_BITS-1:0]  remx;
        logic [REM_BITS-1:0]  trial;
        sq_stage_t            nxt;

        always_comb
        begin
            rad   = (2 * SQ_BITS)'(st_reg[k].disc) << (2 * FRAC_BITS);
            remx  = {st_reg[k].rem[REM_BITS-3:0], rad[2*P+1 -: 2]};
            trial = {st_reg[k].root, 2'b01};
            nxt   = st_reg[k];
            if (remx >= trial)
            begin
                nxt.rem  = remx - trial;
                nxt.root = {st_reg[k].root[SQ_BITS-2:0], 1'b1};
            end
            else
            begin
                nxt.rem  = remx;
                nxt.root = {st_reg[k].root[SQ_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[k+1] <= nxt;
            end
        end
    end

    assign out_valid         = vld_reg[SQ_BITS];
    assign out_res.status    = st_reg[SQ_BITS].status;
    assign out_res.num_plus  = st_reg[SQ_BITS].nb + NUM_BITS'(st_reg[SQ_BITS].root);
    assign out_res.num_minus = st_reg[SQ_BITS].nb - NUM_BITS'(st_reg[SQ_BITS].root);
    assign out_res.den       = st_reg[SQ_BITS].den;

endmodule

// ===== hdl/qrs_div.sv =====
module qrs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  qrs_pkg::sq_res_t   in_res,
    output logic               out_valid,
    output qrs_pkg::out_word_t out_word
);
    import qrs_pkg::*;

    typedef struct packed {
        status_t              status;
        logic                 neg_p;
        logic                 neg_m;
        logic [MAG_BITS-1:0]  mag_p;
        logic [MAG_BITS-1:0]  mag_m;
        logic [DVM_BITS-1:0]  dv;
        logic [DREM_BITS-1:0] r_p;
        logic [DREM_BITS-1:0] r_m;
        logic [MAG_BITS-1:0]  q_p;
        logic [MAG_BITS-1:0]  q_m;
    } dv_stage_t;

    localparam logic signed [WW_BITS-1:0] OMAX = (WW_BITS'(1) <<< (OUT_BITS - 1)) - 1;
    localparam logic signed [WW_BITS-1:0] OMIN = -OMAX - 1;

    logic      vld_reg [MAG_BITS+1];
    dv_stage_t st_reg  [MAG_BITS+1];
    logic      den_neg;

    assign den_neg = in_res.den < 0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0].status <= in_res.status;
            st_reg[0].neg_p  <= (in_res.num_plus < 0) ^ den_neg;
            st_reg[0].neg_m  <= (in_res.num_minus < 0) ^ den_neg;
            st_reg[0].mag_p  <= MAG_BITS'((in_res.num_plus < 0) ? -in_res.num_plus
                                                                 : in_res.num_plus);
            st_reg[0].mag_m  <= MAG_BITS'((in_res.num_minus < 0) ? -in_res.num_minus
                                                                  : in_res.num_minus);
            st_reg[0].dv     <= DVM_BITS'(den_neg ? -in_res.den : in_res.den);
            st_reg[0].r_p    <= '0;
            st_reg[0].r_m    <= '0;
            st_reg[0].q_p    <= '0;
            st_reg[0].q_m    <= '0;
        end
    end

    // restoring division, one quotient bit per stage for both lanes
    for (genvar k = 0; k < MAG_BITS; k++)
    begin : g_stage
        localparam int B = MAG_BITS - 1 - k;
        logic [DREM_BITS-1:0] rx_p;
        logic [DREM_BITS-1:0] rx_m;
        logic [DREM_BITS-1:0] dvx;
        dv_stage_t            nxt;

        always_comb
        begin
            rx_p = {st_reg[k].r_p[DREM_BITS-2:0], st_reg[k].mag_p[B]};
            rx_m = {st_reg[k].r_m[DREM_BITS-2:0], st_reg[k].mag_m[B]};
            dvx  = DREM_BITS'(st_reg[k].dv);
            nxt  = st_reg[k];
            if (rx_p >= dvx)
            begin
                nxt.r_p = rx_p - dvx;
                nxt.q_p = {st_reg[k].q_p[MAG_BITS-2:0], 1'b1};
            end
            else
            begin
                nxt.r_p = rx_p;
                nxt.q_p = {st_reg[k].q_p[MAG_BITS-2:0], 1'b0};
            end
            if (rx_m >= dvx)
            begin
                nxt.r_m = rx_m - dvx;
                nxt.q_m = {st_reg[k].q_m[MAG_BITS-2:0], 1'b1};
            end
            else
            begin
                nxt.r_m = rx_m;
                nxt.q_m = {st_reg[k].q_m[MAG_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[k+1] <= nxt;
            end
        end
    end

    // sign, saturation and zeroing of flagged words
    logic signed [WW_BITS-1:0] sv_p;
    logic signed [WW_BITS-1:0] sv_m;
    logic signed [WW_BITS-1:0] cl_p;
    logic signed [WW_BITS-1:0] cl_m;
    logic                      ok;

    always_comb
    begin
        sv_p = st_reg[MAG_BITS].neg_p ? -$signed(WW_BITS'(st_reg[MAG_BITS].q_p))
                                      :  $signed(WW_BITS'(st_reg[MAG_BITS].q_p));
        sv_m = st_reg[MAG_BITS].neg_m ? -$signed(WW_BITS'(st_reg[MAG_BITS].q_m))
                                      :  $signed(WW_BITS'(st_reg[MAG_BITS].q_m));
        cl_p = (sv_p > OMAX) ? OMAX : ((sv_p < OMIN) ? OMIN : sv_p);
        cl_m = (sv_m > OMAX) ? OMAX : ((sv_m < OMIN) ? OMIN : sv_m);
        ok   = (st_reg[MAG_BITS].status == ST_OK);
        out_word.root_plus  = ok ? cl_p[OUT_BITS-1:0] : '0;
        out_word.root_minus = ok ? cl_m[OUT_BITS-1:0] : '0;
        out_word.status     = st_reg[MAG_BITS].status;
    end

    assign out_valid = vld_reg[MAG_BITS];

endmodule

// ===== hdl/quadratic_root_solver.sv =====
// throughput: one word per cycle unless stalled, set by the root and divider pipelines
// the whole back pipeline holds while a finished word waits on root_stall
// the two-slot queue lets the front keep accepting while the back is held, until it fills
// reset: rst_n asynchronous, active low; clears all valid bits and the queue count
module quadratic_root_solver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               coef_valid,
    output logic               coef_stall,
    input  qrs_pkg::in_word_t  coefs,
    output logic               root_valid,
    input  logic               root_stall,
    output qrs_pkg::out_word_t roots
);
    import qrs_pkg::*;

    // front to queue
    logic    push;
    job_t    push_job;
    logic    q_full;
    logic    q_not_empty;
    job_t    q_head;

    // back pipeline control
    logic    adv;
    logic    pop;
    logic    sq_valid;
    sq_res_t sq_res;

    // back moves whenever the output word is empty or being taken
    assign adv = !root_valid || !root_stall;
    assign pop = adv && q_not_empty;

    // front: registers products, then classifies into a job word
    qrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_valid (coef_valid),
        .coef_stall (coef_stall),
        .coefs      (coefs),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    // short queue decoupling front and back
    qrs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // pipelined square root of the discriminant with fraction bits
    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pop),
        .in_job    (q_head),
        .out_valid (sq_valid),
        .out_res   (sq_res)
    );

    // pipelined truncating divide of both numerators by 2a
    qrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_res    (sq_res),
        .out_valid (root_valid),
        .out_word  (roots)
    );

endmodule

// ===== hdl/qrs_checker.sv =====
module qrs_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               coef_valid,
    input  logic               coef_stall,
    input  qrs_pkg::in_word_t  coefs,
    input  logic               root_valid,
    input  logic               root_stall,
    input  qrs_pkg::out_word_t roots
);
    import qrs_pkg::*;

    // a held word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_stall |=> root_valid && $stable(roots))
        else $error("output word changed while stalled");

    // flagged words carry zero roots
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && roots.status != ST_OK |-> roots.root_plus == '0 && roots.root_minus == '0)
        else $error("flagged word with nonzero roots");

    // status code is one of the three defined
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid |-> roots.status == ST_OK || roots.status == ST_NEG_DISC
                       || roots.status == ST_A_ZERO)
        else $error("undefined status code");

    // no word comes out in the first cycle after reset
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !root_valid)
        else $error("output valid right after reset");

    // a stalled input word is held until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && coef_stall |=> coef_valid && $stable(coefs))
        else $error("input word changed while stalled");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef_valid (coef_valid),
    .coef_stall (coef_stall),
    .coefs      (coefs),
    .root_valid (root_valid),
    .root_stall (root_stall),
    .roots      (roots)
);
